### hdl/teq_pkg.sv
// Package for the timed event queue: field widths, command/result codes,
// cell control type and controller states. No dependencies.

package teq_pkg;

	localparam int CMD_BITS   = 2;
	localparam int ID_BITS    = 4;
	localparam int ID_COUNT   = 1 << ID_BITS;
	localparam int DELAY_BITS = 32;
	localparam int NOW_BITS   = 48;
	localparam int KIND_BITS  = 2;
	localparam int ND_BITS    = 49;
	localparam int WAKE_BITS  = 48;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TIME_BITS_DEF   = 48;

	localparam logic signed [ND_BITS-1:0] ND_EMPTY = -49'sd1;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_CANCEL  = 2'd1,
		CMD_FIRE    = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_FIRED  = 2'd0,
		KIND_DONE   = 2'd1,
		KIND_ACK    = 2'd2,
		KIND_REJECT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_REMOVE,
		OP_POP
	} cell_op_t;

	typedef struct packed {
		cell_op_t             op;
		logic [ID_BITS-1:0]   id;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_ACK,
		ST_FIRE
	} state_t;

endpackage

### hdl/teq_req_if.sv
// Request channel of the timed event queue: valid/ready plus command payload.
// Depends on teq_pkg.

interface teq_req_if;
	logic                          valid;
	logic                          ready;
	logic [teq_pkg::CMD_BITS-1:0]   cmd;
	logic [teq_pkg::ID_BITS-1:0]    event_id;
	logic [teq_pkg::DELAY_BITS-1:0] delay;
	logic [teq_pkg::NOW_BITS-1:0]   now;

	modport source (output valid, cmd, event_id, delay, now, input ready);
	modport sink (input valid, cmd, event_id, delay, now, output ready);
endinterface

### hdl/teq_rsp_if.sv
// Result channel of the timed event queue: valid/ready plus result payload.
// Depends on teq_pkg.

interface teq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [teq_pkg::KIND_BITS-1:0]        kind;
	logic [teq_pkg::ID_BITS-1:0]          fired_id;
	logic signed [teq_pkg::ND_BITS-1:0]   next_delay;
	logic [teq_pkg::WAKE_BITS-1:0]        wake_time;
	logic                                queue_empty;
	logic                                last;

	modport source (output valid, kind, fired_id, next_delay, wake_time, queue_empty, last,
		input ready);
	modport sink (input valid, kind, fired_id, next_delay, wake_time, queue_empty, last,
		output ready);
endinterface

### hdl/teq_cell.sv
// One slot of the sorted event chain: holds a due time and an id, and takes
// a new entry or a neighbor's entry on insert, remove and pop.
// Depends on teq_pkg.

module teq_cell #(
	parameter int TIME_BITS = teq_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  teq_pkg::cell_ctl_t           ctl,
	input  logic [TIME_BITS-1:0]         new_time,
	input  logic                         occ,
	input  logic                         left_less,
	input  logic [TIME_BITS-1:0]         left_time,
	input  logic [teq_pkg::ID_BITS-1:0]  left_id,
	input  logic [TIME_BITS-1:0]         right_time,
	input  logic [teq_pkg::ID_BITS-1:0]  right_id,
	input  logic                         prior_hit,
	output logic                         less,
	output logic                         hit,
	output logic [TIME_BITS-1:0]         slot_time_q,
	output logic [teq_pkg::ID_BITS-1:0]  slot_id_q
);

	// strictly earlier than the new entry: new entries go ahead of equal times
	assign less = occ && (slot_time_q < new_time);
	// this slot or an earlier one holds the id being removed
	assign hit  = prior_hit || (occ && (slot_id_q == ctl.id));

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			teq_pkg::OP_INSERT: begin
				if (!less) begin
					if (left_less) begin
						slot_time_q <= new_time;
						slot_id_q   <= ctl.id;
					end else begin
						slot_time_q <= left_time;
						slot_id_q   <= left_id;
					end
				end
			end
			teq_pkg::OP_REMOVE: begin
				if (hit) begin
					slot_time_q <= right_time;
					slot_id_q   <= right_id;
				end
			end
			teq_pkg::OP_POP: begin
				slot_time_q <= right_time;
				slot_id_q   <= right_id;
			end
			default: begin
			end
		endcase
	end

endmodule

### hdl/timed_event_queue.sv
// Top level of the timed event queue: controller, result register and the
// sorted chain of teq_cell slots. Depends on teq_pkg, teq_req_if, teq_rsp_if, teq_cell.
//
//   channel | modport | transaction carries
//   --------+---------+----------------------------------------------------
//   req     | sink    | cmd, event_id, delay, now
//   rsp     | source  | kind, fired_id, next_delay, wake_time, queue_empty, last
//
// Sequencing: enqueue, cancel and clear are accepted, then one state inserts or
// acknowledges. Fire due pops one event per cycle through the cell chain while
// the result register can take it, then gives the done result.
// The chain shifts one slot per cycle while popping, which sets the pop rate.
// Reset clears the entry count and the queued flags; slot contents are not
// cleared, only slots below the count are ever read. A stalled rsp holds the
// controller in its insert, ack or fire state; req is taken only while idle.

module timed_event_queue #(
	parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF,
	parameter int TIME_BITS   = teq_pkg::TIME_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	teq_req_if.sink   req,
	teq_rsp_if.source rsp
);

	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_BITS  = teq_pkg::ID_BITS;
	localparam int ID_COUNT = teq_pkg::ID_COUNT;
	localparam int ND_BITS  = teq_pkg::ND_BITS;

	teq_pkg::state_t state_q, state_nxt;

	// latched item
	logic [ID_BITS-1:0]   id_q;
	logic [TIME_BITS-1:0] wake_q;
	logic [TIME_BITS-1:0] now_q;

	// queue bookkeeping
	logic [CNT_BITS-1:0]  count_q;
	logic [ID_COUNT-1:0]  flags_q;

	// result register
	logic                      out_valid_q;
	teq_pkg::kind_t            kind_q;
	logic [ID_BITS-1:0]        fid_q;
	logic signed [ND_BITS-1:0] nd_q;
	logic [teq_pkg::WAKE_BITS-1:0] wk_q;
	logic                      empty_q;
	logic                      last_q;

	// next result
	logic                      emit;
	teq_pkg::kind_t            res_kind;
	logic [ID_BITS-1:0]        res_id;
	logic signed [ND_BITS-1:0] res_nd;
	logic [TIME_BITS-1:0]      res_wake;
	logic                      res_empty;
	logic                      res_last;

	// chain control
	teq_pkg::cell_ctl_t   cell_ctl;
	logic [TIME_BITS-1:0] cell_time [QUEUE_DEPTH];
	logic [ID_BITS-1:0]   cell_id   [QUEUE_DEPTH];
	logic [QUEUE_DEPTH:0] less_c;
	logic [QUEUE_DEPTH:0] hit_c;
	logic [QUEUE_DEPTH-1:0] occ;

	logic       accept;
	logic       load_ok;
	logic       rm_hit;
	logic       full;
	logic       head_due;
	teq_pkg::cmd_t in_cmd;
	logic [TIME_BITS-1:0] in_now;
	logic [TIME_BITS-1:0] in_wake;
	logic [ND_BITS-1:0]   head_diff;

	assign in_cmd    = teq_pkg::cmd_t'(req.cmd);
	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == teq_pkg::ST_IDLE);
	// result register can take a new result this cycle
	assign load_ok   = !out_valid_q || rsp.ready;

	// wake time wraps at the time width
	assign in_now  = TIME_BITS'(req.now);
	assign in_wake = in_now + TIME_BITS'(req.delay);

	// remove an already queued id on enqueue or cancel
	assign rm_hit = accept && ((in_cmd == teq_pkg::CMD_ENQUEUE) ||
		(in_cmd == teq_pkg::CMD_CANCEL)) && flags_q[req.event_id];

	assign full      = (count_q >= CNT_BITS'(QUEUE_DEPTH));
	assign head_due  = (count_q != '0) && (cell_time[0] == now_q);
	assign head_diff = ND_BITS'(cell_time[0]) - ND_BITS'(now_q);

	// occupancy: slots below the count hold live entries
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			occ[i] = (CNT_BITS'(i) < count_q);
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			teq_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (in_cmd)
						teq_pkg::CMD_ENQUEUE: state_nxt = teq_pkg::ST_INSERT;
						teq_pkg::CMD_FIRE:    state_nxt = teq_pkg::ST_FIRE;
						default:              state_nxt = teq_pkg::ST_ACK;
					endcase
				end
			end
			teq_pkg::ST_INSERT,
			teq_pkg::ST_ACK: begin
				if (load_ok) state_nxt = teq_pkg::ST_IDLE;
			end
			teq_pkg::ST_FIRE: begin
				if (load_ok && !head_due) state_nxt = teq_pkg::ST_IDLE;
			end
			default: state_nxt = teq_pkg::ST_IDLE;
		endcase
	end

	// outputs: chain operation and next result
	always_comb begin
		cell_ctl.op = teq_pkg::OP_HOLD;
		cell_ctl.id = id_q;
		emit        = 1'b0;
		res_kind    = teq_pkg::KIND_ACK;
		res_id      = id_q;
		res_nd      = '0;
		res_wake    = '0;
		res_empty   = (count_q == '0);
		res_last    = 1'b1;
		unique case (state_q)
			teq_pkg::ST_IDLE: begin
				if (rm_hit) begin
					cell_ctl.op = teq_pkg::OP_REMOVE;
					cell_ctl.id = req.event_id;
				end
			end
			teq_pkg::ST_INSERT: begin
				emit     = load_ok;
				res_wake = wake_q;
				if (full) begin
					res_kind = teq_pkg::KIND_REJECT;
				end else begin
					res_empty = 1'b0;
					if (load_ok) cell_ctl.op = teq_pkg::OP_INSERT;
				end
			end
			teq_pkg::ST_ACK: begin
				emit = load_ok;
			end
			teq_pkg::ST_FIRE: begin
				emit = load_ok;
				if (head_due) begin
					res_kind  = teq_pkg::KIND_FIRED;
					res_id    = cell_id[0];
					res_wake  = cell_time[0];
					res_empty = (count_q == CNT_BITS'(1));
					res_last  = 1'b0;
					if (load_ok) cell_ctl.op = teq_pkg::OP_POP;
				end else begin
					res_kind = teq_pkg::KIND_DONE;
					res_id   = '0;
					if (count_q == '0) begin
						res_nd = teq_pkg::ND_EMPTY;
					end else begin
						res_nd   = head_diff;
						res_wake = cell_time[0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= teq_pkg::ST_IDLE;
			count_q     <= '0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			priority if (accept && (in_cmd == teq_pkg::CMD_CLEAR)) begin
				count_q <= '0;
				flags_q <= '0;
			end else if (cell_ctl.op == teq_pkg::OP_REMOVE) begin
				count_q              <= count_q - CNT_BITS'(1);
				flags_q[cell_ctl.id] <= 1'b0;
			end else if (cell_ctl.op == teq_pkg::OP_INSERT) begin
				count_q              <= count_q + CNT_BITS'(1);
				flags_q[cell_ctl.id] <= 1'b1;
			end else if (cell_ctl.op == teq_pkg::OP_POP) begin
				count_q             <= count_q - CNT_BITS'(1);
				flags_q[cell_id[0]] <= 1'b0;
			end else begin
			end
		end
	end

	// latched item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			// clear acknowledges with id zero
			id_q   <= (in_cmd == teq_pkg::CMD_CLEAR) ? '0 : req.event_id;
			wake_q <= in_wake;
			now_q  <= in_now;
		end
		if (emit) begin
			kind_q  <= res_kind;
			fid_q   <= res_id;
			nd_q    <= res_nd;
			wk_q    <= teq_pkg::WAKE_BITS'(res_wake);
			empty_q <= res_empty;
			last_q  <= res_last;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.kind        = kind_q;
	assign rsp.fired_id    = fid_q;
	assign rsp.next_delay  = nd_q;
	assign rsp.wake_time   = wk_q;
	assign rsp.queue_empty = empty_q;
	assign rsp.last        = last_q;

	// sorted chain: slot 0 is the head; the phantom left of slot 0 counts as
	// earlier than anything, so an insert at the head lands in slot 0
	assign less_c[0] = 1'b1;
	assign hit_c[0]  = 1'b0;

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		logic [TIME_BITS-1:0] l_time, r_time;
		logic [ID_BITS-1:0]   l_id, r_id;

		if (g == 0) begin : g_first
			assign l_time = cell_time[g];
			assign l_id   = cell_id[g];
		end else begin : g_mid
			assign l_time = cell_time[g-1];
			assign l_id   = cell_id[g-1];
		end

		if (g == QUEUE_DEPTH - 1) begin : g_tail
			assign r_time = cell_time[g];
			assign r_id   = cell_id[g];
		end else begin : g_body
			assign r_time = cell_time[g+1];
			assign r_id   = cell_id[g+1];
		end

		teq_cell #(
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk         (clk),
			.ctl         (cell_ctl),
			.new_time    (wake_q),
			.occ         (occ[g]),
			.left_less   (less_c[g]),
			.left_time   (l_time),
			.left_id     (l_id),
			.right_time  (r_time),
			.right_id    (r_id),
			.prior_hit   (hit_c[g]),
			.less        (less_c[g+1]),
			.hit         (hit_c[g+1]),
			.slot_time_q (cell_time[g]),
			.slot_id_q   (cell_id[g])
		);
	end

endmodule
